FILE: hw/rtl/xpbt_pkg.sv
// Package: shared types and constants for the XOR prefix bucket table
`timescale 1ns / 1ps
`default_nettype none
package xpbt_pkg;
    localparam int NUM_BUCKETS  = 64;
    localparam int BUCKET_BITS  = 6;
    localparam int TTL_BITS     = 23;
    localparam int TIME_BITS    = 32;
    localparam int STATUS_BITS  = 2;
    localparam int MS_PER_SEC   = 1000;
    localparam int LIMIT_BITS   = 33;

    typedef enum logic [0:0] {
        CMD_STORE = 1'b0,
        CMD_FIND  = 1'b1
    } command_t;

    typedef enum logic [1:0] {
        ST_STORED   = 2'd0,
        ST_FULL     = 2'd1,
        ST_FOUND    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_FILL,
        BK_READ,
        BK_CHECK,
        BK_MULT,
        BK_DONE
    } back_state_t;

    typedef struct packed {
        logic [0:0]            command;
        logic [63:0]           key;
        logic [63:0]           store_value;
        logic [TTL_BITS-1:0]   ttl_seconds;
        logic [TIME_BITS-1:0]  now_ms;
        logic [BUCKET_BITS-1:0] bucket;
    } work_t;
endpackage
`default_nettype wire

FILE: hw/rtl/xpbt_if.sv
// Interfaces: valid/ready channels for requests, results and configuration
`timescale 1ns / 1ps
`default_nettype none
interface xpbt_req_if;
    logic        valid;
    logic        ready;
    logic [0:0]  command;
    logic [63:0] key;
    logic [63:0] store_value;
    logic [22:0] ttl_seconds;
    logic [31:0] now_ms;
    modport source (output valid, command, key, store_value, ttl_seconds, now_ms,
                    input ready);
    modport sink (input valid, command, key, store_value, ttl_seconds, now_ms,
                  output ready);
endinterface

interface xpbt_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] found_value;
    logic [5:0]  bucket;
    modport source (output valid, status, found_value, bucket, input ready);
    modport sink (input valid, status, found_value, bucket, output ready);
endinterface

interface xpbt_cfg_if;
    logic        valid;
    logic        ready;
    logic [63:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/xpbt_front.sv
// Front end: accepts requests, computes the bucket index, registers the work item
`timescale 1ns / 1ps
`default_nettype none
module xpbt_front #(
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [63:0]   local_id,
    xpbt_req_if.sink           req,
    output xpbt_pkg::work_t    out_work,
    output logic               out_valid,
    input  wire logic          out_ready
);
    import xpbt_pkg::*;

    logic [KEY_BITS-1:0]    diff;
    logic [BUCKET_BITS-1:0] bkt;
    logic [63:0]            key_n;
    logic [63:0]            val_n;
    logic                   valid_reg;
    work_t                  work_reg;

    always_comb
    begin
        diff = req.key[KEY_BITS-1:0] ^ local_id[KEY_BITS-1:0];
        bkt  = '0;
        for (int i = 0; i < KEY_BITS; i++)
        begin
            if (diff[i])
            begin
                bkt = BUCKET_BITS'(KEY_BITS - 1 - i);
            end
        end
        key_n = 64'(req.key[KEY_BITS-1:0]);
        val_n = 64'(req.store_value[VALUE_BITS-1:0]);
    end

    assign req.ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_work  = work_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            work_reg <= '{command: req.command, key: key_n, store_value: val_n,
                          ttl_seconds: req.ttl_seconds, now_ms: req.now_ms,
                          bucket: bkt};
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/xpbt_queue.sv
// Two-entry queue between front end and back end
`timescale 1ns / 1ps
`default_nettype none
module xpbt_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire xpbt_pkg::work_t  in_work,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output xpbt_pkg::work_t       out_work,
    output logic                  out_valid,
    input  wire logic             out_ready
);
    import xpbt_pkg::*;

    work_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_work  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_work;
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/xpbt_back.sv
// Back end: bucket fill counts, entry memory, store and scanning find
`timescale 1ns / 1ps
`default_nettype none
module xpbt_back #(
    parameter int ENTRIES_PER_BUCKET = 20,
    parameter int VALUE_BITS         = 64
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire xpbt_pkg::work_t in_work,
    input  wire logic            in_valid,
    output logic                 in_ready,
    xpbt_rsp_if.source           rsp
);
    import xpbt_pkg::*;

    localparam int DEPTH     = NUM_BUCKETS * ENTRIES_PER_BUCKET;
    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam int FILL_BITS = $clog2(ENTRIES_PER_BUCKET + 1);
    localparam int ENT_BITS  = 64 + VALUE_BITS + TIME_BITS + TTL_BITS;

    logic [ENT_BITS-1:0]  ent_mem [DEPTH];
    logic [ENT_BITS-1:0]  rd_data_reg;
    logic [FILL_BITS-1:0] fill_reg [NUM_BUCKETS];

    back_state_t          state_reg, state_next;
    work_t                work_reg;
    logic [FILL_BITS-1:0] fill_cur_reg, fill_cur_next;
    logic [FILL_BITS-1:0] idx_reg, idx_next;
    logic [ADDR_BITS-1:0] base_reg, base_next;
    logic [ADDR_BITS-1:0] rd_addr;
    logic                 rd_en;
    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_addr;
    logic                 fill_inc;
    logic [LIMIT_BITS-1:0] limit_reg, limit_next;
    logic [TIME_BITS-1:0] age_reg, age_next;
    logic [VALUE_BITS-1:0] hit_val_reg, hit_val_next;
    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           status_reg, status_next;
    logic [63:0]          found_reg, found_next;
    logic                 load;

    logic [63:0]          e_key;
    logic [VALUE_BITS-1:0] e_val;
    logic [TIME_BITS-1:0] e_stamp;
    logic [TTL_BITS-1:0]  e_ttl;

    assign {e_key, e_val, e_stamp, e_ttl} = rd_data_reg;

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.found_value = found_reg;
    assign rsp.bucket      = work_reg.bucket;

    assign in_ready = (state_reg == BK_IDLE) && (!out_valid_reg || rsp.ready);
    assign load     = in_valid && in_ready;
    assign rd_addr  = base_reg + ADDR_BITS'(idx_reg);
    assign wr_addr  = base_reg + ADDR_BITS'(fill_cur_reg);

    always_comb
    begin
        state_next     = state_reg;
        fill_cur_next  = fill_cur_reg;
        idx_next       = idx_reg;
        base_next      = base_reg;
        limit_next     = limit_reg;
        age_next       = age_reg;
        hit_val_next   = hit_val_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        fill_inc       = 1'b0;
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            BK_IDLE:
            begin
                if (load)
                begin
                    base_next  = ADDR_BITS'(in_work.bucket * ENTRIES_PER_BUCKET);
                    idx_next   = '0;
                    state_next = BK_FILL;
                end
            end
            BK_FILL:
            begin
                fill_cur_next = fill_reg[work_reg.bucket];
                state_next    = BK_READ;
            end
            BK_READ:
            begin
                if (work_reg.command == CMD_STORE)
                begin
                    if (fill_cur_reg >= FILL_BITS'(ENTRIES_PER_BUCKET))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        fill_inc    = 1'b1;
                        status_next = ST_STORED;
                    end
                    found_next = '0;
                    state_next = BK_DONE;
                end
                else if (idx_reg >= fill_cur_reg)
                begin
                    status_next = ST_NOTFOUND;
                    found_next  = '0;
                    state_next  = BK_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = BK_CHECK;
                end
            end
            BK_CHECK:
            begin
                age_next     = work_reg.now_ms - e_stamp;
                limit_next   = LIMIT_BITS'(e_ttl) * LIMIT_BITS'(MS_PER_SEC);
                hit_val_next = e_val;
                idx_next     = idx_reg + 1'b1;
                state_next   = (e_key == work_reg.key) ? BK_MULT : BK_READ;
            end
            BK_MULT:
            begin
                if (LIMIT_BITS'(age_reg) < limit_reg)
                begin
                    status_next = ST_FOUND;
                    found_next  = 64'(hit_val_reg);
                    state_next  = BK_DONE;
                end
                else
                begin
                    state_next = BK_READ;
                end
            end
            BK_DONE:
            begin
                out_valid_next = 1'b1;
                state_next     = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            for (int b = 0; b < NUM_BUCKETS; b++)
            begin
                fill_reg[b] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (fill_inc)
            begin
                fill_reg[work_reg.bucket] <= fill_cur_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            work_reg <= in_work;
        end
        fill_cur_reg <= fill_cur_next;
        idx_reg      <= idx_next;
        base_reg     <= base_next;
        limit_reg    <= limit_next;
        age_reg      <= age_next;
        hit_val_reg  <= hit_val_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ent_mem[wr_addr] <= {work_reg.key, work_reg.store_value[VALUE_BITS-1:0],
                                 work_reg.now_ms, work_reg.ttl_seconds};
        end
        if (rd_en)
        begin
            rd_data_reg <= ent_mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/xor_prefix_bucket_table_unit.sv
// Top level: XOR prefix bucket table, keyed store with expiry
// Keys go to one of 64 buckets by the leading bit where they differ from local_id.
// A store passes through the back end states fill, read and done. A find scans
// the bucket from its first entry, reading the entry memory one entry at a time,
// and for a matching key checks its age against ttl_seconds * 1000. The front end
// and a two-entry queue take new transactions while the back end works.
// Entries are never removed; a full bucket reports full until reset.
`timescale 1ns / 1ps
`default_nettype none
module xor_prefix_bucket_table_unit #(
    parameter int KEY_BITS           = 64,
    parameter int ENTRIES_PER_BUCKET = 20,
    parameter int VALUE_BITS         = 64
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    xpbt_cfg_if.sink   cfg,
    xpbt_req_if.sink   req,
    xpbt_rsp_if.source rsp
);
    import xpbt_pkg::*;

    logic [63:0] local_id_reg;
    work_t       f_work;
    logic        f_valid;
    logic        f_ready;
    work_t       q_work;
    logic        q_valid;
    logic        q_ready;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_id_reg <= '0;
        end
        else if (cfg.valid)
        begin
            local_id_reg <= cfg.data;
        end
    end

    xpbt_front #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .local_id(local_id_reg), .req(req),
        .out_work(f_work), .out_valid(f_valid), .out_ready(f_ready)
    );

    xpbt_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_work(f_work), .in_valid(f_valid), .in_ready(f_ready),
        .out_work(q_work), .out_valid(q_valid), .out_ready(q_ready)
    );

    xpbt_back #(.ENTRIES_PER_BUCKET(ENTRIES_PER_BUCKET), .VALUE_BITS(VALUE_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .in_work(q_work), .in_valid(q_valid), .in_ready(q_ready), .rsp(rsp)
    );
endmodule
`default_nettype wire

FILE: verif/xor_prefix_bucket_table_unit_tb.sv
// Testbench: random and directed regression of the XOR prefix bucket table
`timescale 1ns / 1ps
module xor_prefix_bucket_table_unit_tb;
    import xpbt_pkg::*;

    localparam int EPB = 20;

    typedef struct {
        command_t    command;
        logic [63:0] key;
        logic [63:0] store_value;
        logic [22:0] ttl_seconds;
        logic [31:0] now_ms;
    } request_t;

    typedef struct {
        status_t     status;
        logic [63:0] found_value;
        logic [5:0]  bucket;
    } response_t;

    logic clk;
    logic rst_n;

    xpbt_cfg_if cfg_bus ();
    xpbt_req_if req_bus ();
    xpbt_rsp_if rsp_bus ();

    xor_prefix_bucket_table_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus.sink),
        .req   (req_bus.sink),
        .rsp   (rsp_bus.source)
    );

    // model state
    logic [63:0] node_id;
    logic [63:0] tbl_keys   [64][EPB];
    logic [63:0] tbl_values [64][EPB];
    logic [31:0] tbl_stamps [64][EPB];
    logic [22:0] tbl_ttls   [64][EPB];
    int          tbl_fill   [64];

    request_t  pending_requests[$];
    response_t expected_responses[$];
    int        fail_count;
    bit        stim_done;
    bit        idle_on;
    int        hold_rsp_cycles;
    int        send_gap;
    int        recv_gap;
    int        issued;
    int        accepted_count;

    function automatic logic [5:0] bucket_of(logic [63:0] key);
        logic [63:0] diff;
        diff = key ^ node_id;
        for (int p = 0; p < 64; p++)
        begin
            if (diff[63 - p])
                return p[5:0];
        end
        return 6'd0;
    endfunction

    function automatic response_t apply_request(request_t r);
        response_t   o;
        logic [5:0]  b;
        logic [31:0] age;
        logic [32:0] lim;
        b = bucket_of(r.key);
        o.bucket = b;
        o.found_value = '0;
        if (r.command == CMD_STORE)
        begin
            if (tbl_fill[b] >= EPB)
                o.status = ST_FULL;
            else
            begin
                tbl_keys[b][tbl_fill[b]]   = r.key;
                tbl_values[b][tbl_fill[b]] = r.store_value;
                tbl_stamps[b][tbl_fill[b]] = r.now_ms;
                tbl_ttls[b][tbl_fill[b]]   = r.ttl_seconds;
                tbl_fill[b]++;
                o.status = ST_STORED;
            end
        end
        else
        begin
            o.status = ST_NOTFOUND;
            for (int i = 0; i < tbl_fill[b]; i++)
            begin
                if (tbl_keys[b][i] == r.key)
                begin
                    age = r.now_ms - tbl_stamps[b][i];
                    lim = 33'(tbl_ttls[b][i]) * 33'd1000;
                    if (33'(age) < lim)
                    begin
                        o.status = ST_FOUND;
                        o.found_value = tbl_values[b][i];
                        break;
                    end
                end
            end
        end
        return o;
    endfunction

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_bus.valid       <= 1'b0;
            req_bus.command     <= CMD_STORE;
            req_bus.key         <= '0;
            req_bus.store_value <= '0;
            req_bus.ttl_seconds <= '0;
            req_bus.now_ms      <= '0;
            send_gap            <= 0;
        end
        else
        begin
            if (req_bus.valid && req_bus.ready)
            begin
                expected_responses.push_back(apply_request('{command_t'(req_bus.command),
                    req_bus.key, req_bus.store_value, req_bus.ttl_seconds,
                    req_bus.now_ms}));
                accepted_count++;
            end
            if (!req_bus.valid || req_bus.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    req_bus.valid <= 1'b0;
                end
                else if (idle_on && $urandom_range(0, 15) == 0)
                begin
                    send_gap <= $urandom_range(1, 11) - 1;
                    req_bus.valid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    request_t r;
                    r = pending_requests.pop_front();
                    req_bus.valid       <= 1'b1;
                    req_bus.command     <= r.command;
                    req_bus.key         <= r.key;
                    req_bus.store_value <= r.store_value;
                    req_bus.ttl_seconds <= r.ttl_seconds;
                    req_bus.now_ms      <= r.now_ms;
                end
                else
                    req_bus.valid <= 1'b0;
            end
        end
    end

    // long receiver stall counter
    always @(posedge clk)
    begin
        if (hold_rsp_cycles > 0)
            hold_rsp_cycles <= hold_rsp_cycles - 1;
    end

    // response monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            recv_gap      <= 0;
        end
        else
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (expected_responses.size() == 0)
                begin
                    $error("unexpected transaction: status %0d", rsp_bus.status);
                    fail_count++;
                end
                else
                begin
                    response_t e;
                    e = expected_responses.pop_front();
                    if (rsp_bus.status !== e.status)
                    begin
                        $error("status: expected %0d actual %0d", e.status, rsp_bus.status);
                        fail_count++;
                    end
                    if (rsp_bus.found_value !== e.found_value)
                    begin
                        $error("found_value: expected %h actual %h",
                               e.found_value, rsp_bus.found_value);
                        fail_count++;
                    end
                    if (rsp_bus.bucket !== e.bucket)
                    begin
                        $error("bucket: expected %0d actual %0d", e.bucket, rsp_bus.bucket);
                        fail_count++;
                    end
                end
            end
            if (hold_rsp_cycles > 0)
            begin
                rsp_bus.ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                rsp_bus.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 15) == 0)
            begin
                recv_gap <= $urandom_range(1, 11) - 1;
                rsp_bus.ready <= 1'b0;
            end
            else
                rsp_bus.ready <= 1'b1;
        end
    end

    function automatic request_t make_request(command_t c, logic [63:0] k,
                                              logic [63:0] v, logic [22:0] t,
                                              logic [31:0] n);
        request_t r;
        r.command = c;
        r.key = k;
        r.store_value = v;
        r.ttl_seconds = t;
        r.now_ms = n;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // key that lands in bucket b under the current local id
    function automatic logic [63:0] key_in_bucket(int b);
        logic [63:0] k;
        k = rand64();
        k = (k & ~(64'h1 << (63 - b))) | (~node_id & (64'h1 << (63 - b)));
        for (int i = 0; i < b; i++)
            k[63 - i] = node_id[63 - i];
        return k;
    endfunction

    task automatic wait_drained();
        while (pending_requests.size() > 0 || req_bus.valid || expected_responses.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_local_id(logic [63:0] id);
        @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= id;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        node_id = id;
    endtask

    task automatic random_phase(int count, int hot_buckets);
        logic [63:0] known_keys[$];
        logic [31:0] clock_ms;
        logic [63:0] k;
        logic [22:0] t;
        clock_ms = $urandom();
        for (int i = 0; i < count; i++)
        begin
            clock_ms += $urandom_range(0, 3000);
            if (known_keys.size() > 0 && $urandom_range(0, 1))
                k = known_keys[$urandom_range(0, known_keys.size() - 1)];
            else if ($urandom_range(0, 3) == 0)
                k = rand64();
            else
                k = key_in_bucket($urandom_range(0, hot_buckets));
            case ($urandom_range(0, 5))
                0: t = 23'd0;
                1: t = 23'h7FFFFF;
                2: t = 23'($urandom());
                default: t = 23'($urandom_range(1, 6));
            endcase
            if ($urandom_range(0, 2) == 0)
            begin
                pending_requests.push_back(make_request(CMD_STORE, k, rand64(), t, clock_ms));
                known_keys.push_back(k);
            end
            else
                pending_requests.push_back(make_request(CMD_FIND, k, rand64(),
                                                        23'($urandom()), clock_ms));
            issued++;
        end
    endtask

    initial
    begin
        logic [63:0] k;
        fail_count = 0;
        stim_done = 0;
        idle_on = 1;
        hold_rsp_cycles = 0;
        issued = 0;
        accepted_count = 0;
        node_id = '0;
        foreach (tbl_fill[i])
            tbl_fill[i] = 0;
        cfg_bus.valid = 1'b0;
        cfg_bus.data  = '0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, bucket 0 and 63, ttl edges, duplicates, wrap
        k = 64'h8000_0000_0000_0000;
        pending_requests.push_back(make_request(CMD_STORE, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
                                                23'd1, 32'hFFFF_FF00));
        pending_requests.push_back(make_request(CMD_FIND, 64'h0, '0, '0, 32'h0000_0100));
        pending_requests.push_back(make_request(CMD_FIND, 64'h0, '0, '0, 32'h0000_02E8));
        pending_requests.push_back(make_request(CMD_STORE, 64'h1, 64'h0, 23'h7FFFFF, 32'h0));
        pending_requests.push_back(make_request(CMD_FIND, 64'h1, '0, '0, 32'hFFFF_FFFF));
        pending_requests.push_back(make_request(CMD_STORE, k, 64'h5, 23'd0, 32'd10));
        pending_requests.push_back(make_request(CMD_FIND, k, '0, '0, 32'd10));
        pending_requests.push_back(make_request(CMD_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1,
                                                23'd4294967, 32'd0));
        pending_requests.push_back(make_request(CMD_FIND, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0,
                                                32'hFFFF_FFFE));
        pending_requests.push_back(make_request(CMD_STORE, 64'h42, 64'hA, 23'd1, 32'd0));
        pending_requests.push_back(make_request(CMD_STORE, 64'h42, 64'hB, 23'd9, 32'd0));
        pending_requests.push_back(make_request(CMD_FIND, 64'h42, '0, '0, 32'd500));
        pending_requests.push_back(make_request(CMD_FIND, 64'h42, '0, '0, 32'd1000));
        pending_requests.push_back(make_request(CMD_FIND, 64'h43, '0, '0, 32'd0));
        // fill bucket 63 (key 1) past capacity
        for (int i = 0; i < EPB + 1; i++)
            pending_requests.push_back(make_request(CMD_STORE, 64'h1, 64'(i), 23'd3, 32'd7));
        issued += 35;
        wait_drained();

        write_local_id(64'hFFFF_FFFF_FFFF_FFFF);
        random_phase(200, 3);
        // long receiver stall while requests keep coming
        hold_rsp_cycles = 400;
        wait_drained();

        write_local_id(rand64());
        random_phase(400, 63);
        wait_drained();

        write_local_id(64'h0);
        random_phase(250, 10);
        repeat (20) @(posedge clk);
        idle_on = 0;
        random_phase(200, 63);
        wait_drained();
        stim_done = 1;
    end

    initial
    begin
        wait (stim_done);
        if (fail_count == 0 && expected_responses.size() == 0)
            $display("xor_prefix_bucket_table_unit regression: pass");
        else
            $display("xor_prefix_bucket_table_unit regression: fail");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("xor_prefix_bucket_table_unit regression: fail");
        $finish;
    end
endmodule

FILE: filelist.f
hw/rtl/xpbt_pkg.sv
hw/rtl/xpbt_if.sv
hw/rtl/xpbt_front.sv
hw/rtl/xpbt_queue.sv
hw/rtl/xpbt_back.sv
hw/rtl/xor_prefix_bucket_table_unit.sv
verif/xor_prefix_bucket_table_unit_tb.sv
